// ===== rtl/invoice_amount_parser_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the invoice amount parser
// Shared macros that wrap concurrent assertions on the block clock, one gated by reset.
// ----------------------------------------------------------------------------
`ifndef INVOICE_AMOUNT_PARSER_CORE_ASSERT_SVH
`define INVOICE_AMOUNT_PARSER_CORE_ASSERT_SVH

// Checked only while the block is out of reset.
`define IAP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IAP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/iap_pkg.sv =====
// ----------------------------------------------------------------------------
// Invoice amount parser package
// Field types, result status codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package iap_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [62:0] amount_t;
	typedef logic [2:0]  status_t;

	localparam int AmountW = 63;
	localparam int QuoW    = 50;
	localparam int RemW    = 14;

	localparam status_t StOk       = 3'd0;
	localparam status_t StNoDigits = 3'd1;
	localparam status_t StNoLetter = 3'd2;
	localparam status_t StUnknown  = 3'd3;
	localparam status_t StOverflow = 3'd4;

	localparam amount_t AmtMax = {AmountW{1'b1}};

	localparam char_t ChrZero  = 8'h30;
	localparam char_t ChrNine  = 8'h39;
	localparam char_t ChrUpA   = 8'h41;
	localparam char_t ChrUpZ   = 8'h5A;
	localparam char_t ChrLowA  = 8'h61;
	localparam char_t ChrLowZ  = 8'h7A;
	localparam char_t ChrMilli = 8'h6D;
	localparam char_t ChrMicro = 8'h75;
	localparam char_t ChrNano  = 8'h6E;
	localparam char_t ChrPico  = 8'h70;

	localparam amount_t LimitMilli = amount_t'(AmtMax / 63'd100000);
	localparam amount_t LimitMicro = amount_t'(AmtMax / 63'd100);

endpackage

`default_nettype wire

// ===== rtl/invoice_amount_parser_core.sv =====
// ----------------------------------------------------------------------------
// Invoice amount parser core
// Parses the amount field of a payment-request string, one character per
// transfer, and returns the scaled amount with a status on the last one.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Contents
//  s_axis   in         tdata[7:0] char_code, tlast = last_char
//  m_axis   out        tdata[62:0] amount_sats, tuser[2:0] status
//
// Each character sits in the input register while the update logic works on
// it; one transfer is accepted per cycle unless the input stalls. A result
// is registered as valid when its last character leaves the input register.
// Reset returns the parser to searching for the first digit. The input stalls
// only when a last character waits for a result register that is still full.
//
`default_nettype none

`include "invoice_amount_parser_core_assert.svh"

module invoice_amount_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // [62:0] amount_sats, [63] zero
	output logic [2:0]       m_axis_tuser   // [2:0] status
);

	localparam logic [1:0] PhSeek   = 2'd0;
	localparam logic [1:0] PhDigits = 2'd1;
	localparam logic [1:0] PhWait   = 2'd2;
	localparam logic [1:0] PhDone   = 2'd3;

	logic                     valid_s1;
	iap_pkg::char_t           char_s1;
	logic                     last_s1;
	logic                     advance_s1;

	logic [1:0]               phase_q;
	iap_pkg::amount_t         value_q;
	iap_pkg::amount_t         prev_q;
	logic [iap_pkg::QuoW-1:0] quo_q;
	logic [iap_pkg::RemW-1:0] rem_q;
	logic                     ovf_q;
	iap_pkg::status_t         status_q;

	logic                     valid_s2;
	iap_pkg::amount_t         amount_s2;
	iap_pkg::status_t         status_s2;

	logic                     is_digit;
	logic                     is_letter;
	logic [3:0]               digit;
	iap_pkg::amount_t         add_base;
	iap_pkg::amount_t         add_base_prev;
	logic [iap_pkg::QuoW-1:0] add_base_quo;
	logic [iap_pkg::RemW-1:0] add_base_rem;
	logic [66:0]              add_sum;
	logic [16:0]              rem_sum;
	logic [3:0]               rem_carry;
	iap_pkg::amount_t         add_value;
	iap_pkg::amount_t         add_prev;
	logic [iap_pkg::QuoW-1:0] add_quo;
	logic [iap_pkg::RemW-1:0] add_rem;
	logic                     add_ovf;
	logic                     add_skip;
	iap_pkg::amount_t         mul_milli;
	iap_pkg::amount_t         mul_micro;
	iap_pkg::amount_t         let_value;
	iap_pkg::status_t         let_status;

	logic [1:0]               phase_d;
	iap_pkg::amount_t         value_d;
	iap_pkg::amount_t         prev_d;
	logic [iap_pkg::QuoW-1:0] quo_d;
	logic [iap_pkg::RemW-1:0] rem_d;
	logic                     ovf_d;
	iap_pkg::status_t         status_d;

	assign advance_s1    = valid_s1 && (!last_s1 || !valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign is_digit  = (char_s1 >= iap_pkg::ChrZero) && (char_s1 <= iap_pkg::ChrNine);
	assign is_letter = ((char_s1 >= iap_pkg::ChrUpA) && (char_s1 <= iap_pkg::ChrUpZ)) ||
		((char_s1 >= iap_pkg::ChrLowA) && (char_s1 <= iap_pkg::ChrLowZ));
	assign digit     = char_s1[3:0];

	// The first digit of a run starts from an empty accumulator.
	assign add_base      = (phase_q == PhSeek) ? '0 : value_q;
	assign add_base_prev = add_base;
	assign add_base_quo  = (phase_q == PhSeek) ? '0 : quo_q;
	assign add_base_rem  = (phase_q == PhSeek) ? '0 : rem_q;
	assign add_skip      = (phase_q != PhSeek) && ovf_q;

	assign add_sum = {1'b0, add_base, 3'b000} + {3'b000, add_base, 1'b0} + {63'd0, digit};
	assign add_ovf = |add_sum[66:63];

	// The quotient and remainder by ten thousand are kept alongside the
	// value, and the value before the last digit is the quotient by ten.
	assign rem_sum = {add_base_rem, 3'b000} + {2'b00, add_base_rem, 1'b0} + {13'd0, digit};

	always_comb begin
		rem_carry = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_sum >= 17'(k * 10000)) begin
				rem_carry = 4'(k);
			end
		end
	end

	assign add_rem   = iap_pkg::RemW'(rem_sum - 17'(rem_carry) * 17'd10000);
	assign add_quo   = {add_base_quo[iap_pkg::QuoW-4:0], 3'b000} +
		{add_base_quo[iap_pkg::QuoW-2:0], 1'b0} + {{(iap_pkg::QuoW-4){1'b0}}, rem_carry};
	assign add_value = add_ovf ? '0 : add_sum[62:0];
	assign add_prev  = add_base_prev;

	// Multiplication by 100000 and 100 as shifted sums.
	assign mul_milli = (value_q << 16) + (value_q << 15) + (value_q << 10) +
		(value_q << 9) + (value_q << 7) + (value_q << 5);
	assign mul_micro = (value_q << 6) + (value_q << 5) + (value_q << 2);

	always_comb begin
		let_value  = '0;
		let_status = iap_pkg::StOk;
		case (char_s1)
			iap_pkg::ChrMilli: begin
				if (ovf_q || (value_q > iap_pkg::LimitMilli)) begin
					let_status = iap_pkg::StOverflow;
				end else begin
					let_value = mul_milli;
				end
			end
			iap_pkg::ChrMicro: begin
				if (ovf_q || (value_q > iap_pkg::LimitMicro)) begin
					let_status = iap_pkg::StOverflow;
				end else begin
					let_value = mul_micro;
				end
			end
			iap_pkg::ChrNano: begin
				if (ovf_q) begin
					let_status = iap_pkg::StOverflow;
				end else begin
					let_value = prev_q;
				end
			end
			iap_pkg::ChrPico: begin
				if (ovf_q) begin
					let_status = iap_pkg::StOverflow;
				end else begin
					let_value = iap_pkg::amount_t'(quo_q);
				end
			end
			default: begin
				let_status = iap_pkg::StUnknown;
			end
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		value_d  = value_q;
		prev_d   = prev_q;
		quo_d    = quo_q;
		rem_d    = rem_q;
		ovf_d    = ovf_q;
		status_d = status_q;
		case (phase_q)
			PhSeek, PhDigits: begin
				if (is_digit) begin
					phase_d  = PhDigits;
					status_d = iap_pkg::StNoLetter;
					if (!add_skip) begin
						value_d = add_value;
						prev_d  = add_prev;
						quo_d   = add_quo;
						rem_d   = add_rem;
						ovf_d   = add_ovf;
					end
				end else if (phase_q == PhDigits) begin
					phase_d = PhWait;
					if (is_letter) begin
						phase_d  = PhDone;
						value_d  = let_value;
						status_d = let_status;
					end
				end
			end
			PhWait: begin
				if (is_letter) begin
					phase_d  = PhDone;
					value_d  = let_value;
					status_d = let_status;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PhSeek;
			ovf_q    <= 1'b0;
			status_q <= iap_pkg::StNoDigits;
		end else if (advance_s1) begin
			if (last_s1) begin
				phase_q  <= PhSeek;
				ovf_q    <= 1'b0;
				status_q <= iap_pkg::StNoDigits;
			end else begin
				phase_q  <= phase_d;
				ovf_q    <= ovf_d;
				status_q <= status_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			value_q <= value_d;
			prev_q  <= prev_d;
			quo_q   <= quo_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			amount_s2 <= (status_d == iap_pkg::StOk) ? value_d : '0;
			status_s2 <= status_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, amount_s2};
	assign m_axis_tuser  = status_s2;

	`IAP_ASSERT(a_amount_zero_unless_ok,
		valid_s2 && (status_s2 != iap_pkg::StOk) |-> (amount_s2 == '0), "amount not zero")
	`IAP_ASSERT(a_status_in_range,
		valid_s2 |-> (status_s2 <= iap_pkg::StOverflow), "status code out of range")
	`IAP_ASSERT(a_seek_means_no_digits,
		(phase_q == PhSeek) |-> (status_q == iap_pkg::StNoDigits) && !ovf_q,
		"seek phase with stale status")
	`IAP_ASSERT(a_stall_only_on_full_output,
		valid_s1 && !advance_s1 |-> last_s1 && valid_s2 && !m_axis_tready,
		"input stage stalled without cause")
	`IAP_ASSERT_ALWAYS(a_reset_clears_valid,
		!arst_n |-> (m_axis_tvalid !== 1'b1), "result valid during reset")

endmodule

`default_nettype wire
